// File: rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Widths, payload types and the divider stage record shared by the
// aspect fit rectangle pipeline.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int unsigned DimBits  = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned OutBits  = DimBits + FracBits;
  localparam int unsigned ProdBits = 2 * DimBits;
  localparam int unsigned QuoBits  = OutBits;

  typedef struct packed {
    logic [DimBits-1:0] src_width;
    logic [DimBits-1:0] src_height;
    logic [DimBits-1:0] dst_width;
    logic [DimBits-1:0] dst_height;
  } in_t;

  typedef struct packed {
    logic [OutBits-1:0] fit_width;
    logic [OutBits-1:0] fit_height;
  } out_t;

  typedef struct packed {
    logic [DimBits-1:0] rem;
    logic [DimBits-1:0] dvs;
    logic [QuoBits-1:0] nq;
    logic [OutBits-1:0] fw;
    logic [OutBits-1:0] fh;
    logic               div_en;
    logic               div_h;
  } div_t;

endpackage

// File: rtl/afr_front.sv
// ----------------------------------------------------------------------------
// afr_front
// Two register stages: cross products of the sizes, then the choice of the
// limiting side and the setup of the long division.
// ----------------------------------------------------------------------------
module afr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  afr_pkg::in_t  in_data_i,
  output logic          valid_o,
  output afr_pkg::div_t data_o
);

  logic                         a_valid_q;
  afr_pkg::in_t                 a_dim_q;
  logic [afr_pkg::ProdBits-1:0] a_pw_q;
  logic [afr_pkg::ProdBits-1:0] a_ph_q;

  logic                         b_valid_q;
  afr_pkg::div_t                b_q;
  afr_pkg::div_t                b_d;

  logic [afr_pkg::ProdBits-1:0] prod;
  logic [afr_pkg::DimBits-1:0]  sw, sh, dw, dh;
  logic                         wlim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dim_q <= in_data_i;
      a_pw_q  <= in_data_i.dst_width * in_data_i.src_height;
      a_ph_q  <= in_data_i.dst_height * in_data_i.src_width;
      b_q     <= b_d;
    end
  end

  always_comb begin
    sw   = a_dim_q.src_width;
    sh   = a_dim_q.src_height;
    dw   = a_dim_q.dst_width;
    dh   = a_dim_q.dst_height;
    wlim = (a_pw_q <= a_ph_q);
    prod = wlim ? a_pw_q : a_ph_q;

    b_d        = '0;
    b_d.dvs    = wlim ? sw : sh;
    b_d.rem    = prod[afr_pkg::ProdBits-1:afr_pkg::DimBits];
    b_d.nq     = afr_pkg::QuoBits'(prod[afr_pkg::DimBits-1:0]) << afr_pkg::FracBits;

    if (sw == '0 && sh == '0) begin
      b_d.fw = '0;
      b_d.fh = '0;
    end else if (sw == '0) begin
      b_d.fw = '0;
      b_d.fh = afr_pkg::OutBits'((dh < sh) ? dh : sh) << afr_pkg::FracBits;
    end else if (sh == '0) begin
      b_d.fh = '0;
      b_d.fw = afr_pkg::OutBits'((dw < sw) ? dw : sw) << afr_pkg::FracBits;
    end else if (dw >= sw && dh >= sh) begin
      b_d.fw = afr_pkg::OutBits'(sw) << afr_pkg::FracBits;
      b_d.fh = afr_pkg::OutBits'(sh) << afr_pkg::FracBits;
    end else if (wlim) begin
      b_d.fw     = afr_pkg::OutBits'(dw) << afr_pkg::FracBits;
      b_d.div_en = 1'b1;
      b_d.div_h  = 1'b1;
    end else begin
      b_d.fh     = afr_pkg::OutBits'(dh) << afr_pkg::FracBits;
      b_d.div_en = 1'b1;
      b_d.div_h  = 1'b0;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

`ifndef SYNTH
  // A division is only set up against a nonzero source side.
  a_front_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_q.div_en |-> b_q.dvs != '0)
    else $error("division set up with a zero divisor");

  // The upper half of the product is below the divisor, so the quotient fits.
  a_front_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_q.div_en |-> b_q.rem < b_q.dvs)
    else $error("quotient would overflow the output width");
`endif

endmodule

// File: rtl/afr_div_step.sv
// ----------------------------------------------------------------------------
// afr_div_step
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module afr_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  afr_pkg::div_t data_i,
  output logic          valid_o,
  output afr_pkg::div_t data_o
);

  logic                        valid_q;
  afr_pkg::div_t               data_q;
  afr_pkg::div_t               data_d;
  logic [afr_pkg::DimBits:0]   trial;
  logic [afr_pkg::DimBits:0]   diff;
  logic                        ge;

  always_comb begin
    trial  = {data_i.rem, data_i.nq[afr_pkg::QuoBits-1]};
    diff   = trial - {1'b0, data_i.dvs};
    ge     = (trial >= {1'b0, data_i.dvs});
    data_d = data_i;
    data_d.rem = ge ? diff[afr_pkg::DimBits-1:0] : trial[afr_pkg::DimBits-1:0];
    data_d.nq  = {data_i.nq[afr_pkg::QuoBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTH
  // The partial remainder stays below the divisor after every step.
  a_step_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.div_en |-> data_q.rem < data_q.dvs)
    else $error("partial remainder not below divisor");
`endif

endmodule

// File: rtl/aspect_fit_rectangle.sv
// ----------------------------------------------------------------------------
// aspect_fit_rectangle
// Fits a source rectangle inside a destination rectangle, keeping the
// aspect ratio and never enlarging it; results are 16.8 fixed point.
// ----------------------------------------------------------------------------
// The block accepts one item in every cycle while in_stall_o is low and
// returns each result in order, after two front stages plus one stage per
// quotient bit. The pipeline depth is set by the restoring
// divider, which produces one quotient bit per register stage. The whole
// pipeline advances together; it holds while a result waits at the output
// under stall, and empty slots are filled while the output is free.
module aspect_fit_rectangle (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  afr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output afr_pkg::out_t out_data_o
);

  logic          en;
  logic          chain_valid [afr_pkg::QuoBits+1];
  afr_pkg::div_t chain_data  [afr_pkg::QuoBits+1];
  afr_pkg::div_t last;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  afr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .valid_o    (chain_valid[0]),
    .data_o     (chain_data[0])
  );

  for (genvar i = 0; i < afr_pkg::QuoBits; i++) begin : g_step
    afr_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  assign last        = chain_data[afr_pkg::QuoBits];
  assign out_valid_o = chain_valid[afr_pkg::QuoBits];

  always_comb begin
    out_data_o.fit_width  = (last.div_en && !last.div_h) ? last.nq : last.fw;
    out_data_o.fit_height = (last.div_en &&  last.div_h) ? last.nq : last.fh;
  end

endmodule
